// ===== design/smtp_scn_pkg.sv =====
// ----------------------------------------------------------------------------
// SMTP scanner package
// Shared response codes, command patterns and stage result structs.
// ----------------------------------------------------------------------------
package smtp_scn_pkg;

	typedef enum logic [2:0] {
		RSP_NONE       = 3'd0,
		RSP_START_DATA = 3'd1,
		RSP_HELLO      = 3'd2,
		RSP_SENDER_OK  = 3'd3,
		RSP_RCPT_OK    = 3'd4,
		RSP_BYE        = 3'd5,
		RSP_QUEUED     = 3'd6,
		RSP_TOO_BIG    = 3'd7
	} resp_t;

	localparam int unsigned WindowBytes = 9;
	localparam int unsigned CountW      = 16;

	// Last character sits in the low byte, matching the history layout.
	localparam logic [47:0] PatData = 48'h44_41_54_41_0D_0A;
	localparam logic [31:0] PatEhlo = "EHLO";
	localparam logic [79:0] PatMail = "MAIL FROM:";
	localparam logic [63:0] PatRcpt = "RCPT TO:";
	localparam logic [31:0] PatQuit = "QUIT";

	// Four stored bytes before the final LF of CR LF . CR LF, oldest highest.
	localparam logic [31:0] TailEnd = 32'h0D_0A_2E_0D;
	localparam logic [7:0]  ByteLf  = 8'h0A;

	typedef struct packed {
		logic  hit;
		logic  is_data;
		logic  is_quit;
		resp_t resp;
	} cmd_res_t;

	typedef struct packed {
		logic              store;
		logic              done;
		resp_t             resp;
		logic [CountW-1:0] index;
		logic [CountW-1:0] msg_len;
	} msg_res_t;

endpackage

// ===== design/smtp_scn_cmd.sv =====
// ----------------------------------------------------------------------------
// SMTP scanner command matcher
// Holds the last nine command-mode bytes and decodes a command ending now.
// ----------------------------------------------------------------------------
module smtp_scn_cmd (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              cur_byte,
	output smtp_scn_pkg::cmd_res_t  res
);

	// newest previous byte in [7:0]
	logic [smtp_scn_pkg::WindowBytes*8-1:0] window_q;
	logic [smtp_scn_pkg::WindowBytes*8+7:0] hist;
	logic                                   m_data, m_ehlo, m_mail, m_rcpt, m_quit;

	assign hist   = {window_q, cur_byte};
	assign m_data = hist[47:0] == smtp_scn_pkg::PatData;
	assign m_ehlo = hist[31:0] == smtp_scn_pkg::PatEhlo;
	assign m_mail = hist[79:0] == smtp_scn_pkg::PatMail;
	assign m_rcpt = hist[63:0] == smtp_scn_pkg::PatRcpt;
	assign m_quit = hist[31:0] == smtp_scn_pkg::PatQuit;

	always_comb begin
		res.is_data = m_data;
		res.is_quit = 1'b0;
		res.resp    = smtp_scn_pkg::RSP_NONE;
		if (m_data) begin
			res.resp = smtp_scn_pkg::RSP_START_DATA;
		end else if (m_ehlo) begin
			res.resp = smtp_scn_pkg::RSP_HELLO;
		end else if (m_mail) begin
			res.resp = smtp_scn_pkg::RSP_SENDER_OK;
		end else if (m_rcpt) begin
			res.resp = smtp_scn_pkg::RSP_RCPT_OK;
		end else if (m_quit) begin
			res.resp    = smtp_scn_pkg::RSP_BYE;
			res.is_quit = 1'b1;
		end
		res.hit = res.resp != smtp_scn_pkg::RSP_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (step) begin
			if (m_data) begin
				window_q <= '0;
			end else begin
				window_q <= hist[smtp_scn_pkg::WindowBytes*8-1:0];
			end
		end
	end

endmodule

// ===== design/smtp_scn_msg.sv =====
// ----------------------------------------------------------------------------
// SMTP scanner message path
// Stores data-mode bytes under the limit and spots the end-of-data tail.
// ----------------------------------------------------------------------------
module smtp_scn_msg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [7:0]                        cur_byte,
	input  logic [smtp_scn_pkg::CountW-1:0]   limit,
	output smtp_scn_pkg::msg_res_t            res
);

	logic [smtp_scn_pkg::CountW-1:0] count_q;
	logic [31:0]                     tail_q;
	logic                            room;

	assign room = count_q < limit;

	always_comb begin
		res.store   = room;
		res.index   = count_q;
		// count_q >= 4 means at least five bytes stored including this one
		res.done    = room && (count_q >= smtp_scn_pkg::CountW'(4))
		              && (tail_q == smtp_scn_pkg::TailEnd)
		              && (cur_byte == smtp_scn_pkg::ByteLf);
		res.msg_len = res.done ? count_q - smtp_scn_pkg::CountW'(4) : '0;
		if (!room) begin
			res.resp = smtp_scn_pkg::RSP_TOO_BIG;
		end else if (res.done) begin
			res.resp = smtp_scn_pkg::RSP_QUEUED;
		end else begin
			res.resp = smtp_scn_pkg::RSP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tail_q  <= '0;
		end else if (step && room) begin
			count_q <= count_q + smtp_scn_pkg::CountW'(1);
			tail_q  <= {tail_q[23:0], cur_byte};
		end
	end

endmodule

// ===== design/smtp_command_and_data_scanner.sv =====
// ----------------------------------------------------------------------------
// SMTP command and data scanner
// Byte-stream scanner for an SMTP receiver: command decode and message store.
// ----------------------------------------------------------------------------
// Takes one byte per clock and keeps that rate indefinitely when the output
// side is ready. Each byte passes an input register and combinational decode,
// then lands in the output register; a stalled byte waits in the input register.
// In command mode only recognized commands produce a result; in data mode
// every byte produces one. data_limit is written through
// data_limit_we/data_limit_wdata and should only change while the block idles.
module smtp_command_and_data_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_limit_we,
	input  logic [15:0] data_limit_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] response, [3] store_valid, [11:4] store_byte, [27:12] store_index,
	// [43:28] message_length, [44] quit_seen, [45] message_ready, [47:46] zero
	output logic [47:0] m_tdata
);

	logic                              in_valid_s1;
	logic [7:0]                        in_byte_s1;
	logic                              advance;
	logic                              data_mode_q, quit_q, ready_q;
	logic [smtp_scn_pkg::CountW-1:0]   limit_q;
	smtp_scn_pkg::cmd_res_t            cmd_res;
	smtp_scn_pkg::msg_res_t            msg_res;
	logic                              emit, quit_nxt, ready_nxt;

	logic                              out_valid_s2;
	smtp_scn_pkg::resp_t               resp_s2;
	logic                              store_s2, quit_s2, ready_s2;
	logic [7:0]                        byte_s2;
	logic [smtp_scn_pkg::CountW-1:0]   index_s2, len_s2;

	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (data_limit_we) begin
			limit_q <= data_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
	end

	smtp_scn_cmd u_cmd (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance && !data_mode_q),
		.cur_byte (in_byte_s1),
		.res      (cmd_res)
	);

	smtp_scn_msg u_msg (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance && data_mode_q),
		.cur_byte (in_byte_s1),
		.limit    (limit_q),
		.res      (msg_res)
	);

	always_comb begin
		emit      = data_mode_q || cmd_res.hit;
		quit_nxt  = quit_q;
		ready_nxt = ready_q;
		if (data_mode_q) begin
			if (msg_res.done) begin
				quit_nxt  = 1'b1;
				ready_nxt = 1'b1;
			end
		end else if (cmd_res.is_quit) begin
			quit_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_mode_q  <= 1'b0;
			quit_q       <= 1'b0;
			ready_q      <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			quit_q       <= quit_nxt;
			ready_q      <= ready_nxt;
			out_valid_s2 <= emit;
			if (data_mode_q) begin
				data_mode_q <= !msg_res.done;
			end else begin
				data_mode_q <= cmd_res.is_data;
			end
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quit_s2  <= quit_nxt;
			ready_s2 <= ready_nxt;
			if (data_mode_q) begin
				resp_s2  <= msg_res.resp;
				store_s2 <= msg_res.store;
				byte_s2  <= msg_res.store ? in_byte_s1 : 8'd0;
				index_s2 <= msg_res.store ? msg_res.index : '0;
				len_s2   <= msg_res.msg_len;
			end else begin
				resp_s2  <= cmd_res.resp;
				store_s2 <= 1'b0;
				byte_s2  <= 8'd0;
				index_s2 <= '0;
				len_s2   <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {2'b00, ready_s2, quit_s2, len_s2, index_s2, byte_s2, store_s2,
	                   resp_s2};

	// a stored byte only ever answers nothing or queued
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && store_s2 |-> resp_s2 == smtp_scn_pkg::RSP_NONE
		                      || resp_s2 == smtp_scn_pkg::RSP_QUEUED)
		else $error("stored byte with unexpected response");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && resp_s2 == smtp_scn_pkg::RSP_TOO_BIG |-> !store_s2)
		else $error("too-big response with stored byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ready_s2 |-> quit_s2)
		else $error("message ready without quit flag");

	// a queued result always returns to command mode
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && data_mode_q && msg_res.done |=> !data_mode_q)
		else $error("still in data mode after end of message");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |=> in_valid_s1 && $stable(in_byte_s1))
		else $error("held input request lost");

endmodule
